[hw/rtl/rkfi_pkg.sv]
// ----------------------------------------------------------------------------
// rkfi_pkg: shared types and constants for the keyframe color interpolator
// Keyframe record layout, command and status codes, sequencer states and
// divider sizing.
// ----------------------------------------------------------------------------
package rkfi_pkg;

    // Command codes on i_op
    localparam logic [1:0] OP_WR_KEY   = 2'd0;
    localparam logic [1:0] OP_WR_COUNT = 2'd1;
    localparam logic [1:0] OP_EVAL     = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_NO_SEGMENT = 2'd1;
    localparam logic [1:0] ST_ZERO_PER   = 2'd2;

    localparam logic [23:0] WHITE_RGB = 24'hFFFFFF;

    // Shared divider: dividend holds |dc * dt| (< 2^24), divisor a 16-bit span
    localparam int DIVIDEND_W = 24;
    localparam int DIVISOR_W  = 16;

    typedef struct packed {
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [15:0] pos;
    } t_key;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LAST,
        S_PERIOD,
        S_MOD,
        S_RD_A,
        S_GET_A,
        S_RD_B,
        S_CHK,
        S_MUL,
        S_DGO,
        S_DIV,
        S_OUT
    } t_state;

endpackage

[hw/rtl/rgb_keyframe_interpolator.sv]
// ----------------------------------------------------------------------------
// rgb_keyframe_interpolator: piecewise linear color gradient over keyframes
// Holds GROUPS color curves of up to POINTS keyframes each and evaluates the
// color of a curve at a requested time.
// ----------------------------------------------------------------------------
// Usage:
//   A command transaction is taken on a rising edge with start high and busy
//   low. i_op selects keyframe write, point count write or evaluate.
//   Writes finish in the accept cycle: busy stays low, no result is produced.
//   An evaluate yields exactly one result: o_valid is high for one cycle with
//   o_out_red/green/blue and o_status. The receiver cannot stall; a result
//   is simply consumed in that cycle.
// Sequence:
//   Invalid group or fewer than two points: result in the cycle after accept.
//   Otherwise the keyframe RAM is read once for the period, the shared
//   24-step divider reduces the time modulo the period, the segment scan
//   reads one keyframe per S_RD_B/S_CHK pass, and each of the three
//   channels takes one multiply step plus one divider pass; a zero-width
//   segment skips the divider. busy is high throughout, so one evaluate
//   is in flight at a time.
// Reset:
//   i_rst_n (synchronous, active low) clears the point counts and the
//   sequencer. Keyframe RAM is not cleared; slots hold garbage until written.
// ----------------------------------------------------------------------------
module rgb_keyframe_interpolator
    import rkfi_pkg::*;
#(
    parameter int GROUPS = 12,
    parameter int POINTS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_op,
    input  logic [3:0]  i_group,
    input  logic [3:0]  i_index,
    input  logic [7:0]  i_red,
    input  logic [7:0]  i_green,
    input  logic [7:0]  i_blue,
    input  logic [15:0] i_position,
    input  logic [4:0]  i_count,
    input  logic [15:0] i_time_req,
    output logic        o_valid,
    output logic [7:0]  o_out_red,
    output logic [7:0]  o_out_green,
    output logic [7:0]  o_out_blue,
    output logic [1:0]  o_status
);

    localparam int GW    = (GROUPS > 1) ? $clog2(GROUPS) : 1;
    localparam int LW    = $clog2(POINTS + 1);
    localparam int DEPTH = GROUPS * POINTS;
    localparam int AW    = $clog2(DEPTH);
    localparam int KW    = $bits(t_key);

    // ---------------- control state ----------------
    t_state      r_state, n_state;
    logic        r_valid, n_valid;
    logic [LW-1:0] r_len [GROUPS];
    logic [LW-1:0] n_len [GROUPS];

    // ---------------- datapath registers ----------------
    logic [AW-1:0]        r_base, n_base;
    logic [LW-1:0]        r_n, n_n;
    logic [LW-1:0]        r_idx, n_idx;
    logic [15:0]          r_time, n_time;
    logic [15:0]          r_tt, n_tt;
    t_key                 r_a, n_a;
    t_key                 r_b, n_b;
    logic signed [16:0]   r_den, n_den;
    logic signed [25:0]   r_prod, n_prod;
    logic                 r_neg, n_neg;
    logic [1:0]           r_chan, n_chan;
    logic [7:0]           r_rgb [3];
    logic [7:0]           n_rgb [3];
    logic [7:0]           r_out_red, n_out_red;
    logic [7:0]           r_out_green, n_out_green;
    logic [7:0]           r_out_blue, n_out_blue;
    logic [1:0]           r_status, n_status;

    // ---------------- RAM and divider hookup ----------------
    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    t_key                  ram_wdata;
    logic [AW-1:0]         ram_raddr;
    logic [KW-1:0]         ram_rdata;
    t_key                  rd_key;
    logic [LW-1:0]         rd_ofs;

    logic                  div_start;
    logic [DIVIDEND_W-1:0] div_dividend;
    logic [DIVISOR_W-1:0]  div_divisor;
    logic                  div_busy;
    logic                  div_done;
    logic [DIVIDEND_W-1:0] div_quo;
    logic [DIVISOR_W-1:0]  div_rem;

    logic                  accept;
    logic [GW-1:0]         grp_sel;
    logic                  grp_ok;
    logic [LW-1:0]         len_sel;

    // channel operands for the current lerp step
    logic [7:0]            c0, c1;
    logic signed [8:0]     dc;
    logic signed [16:0]    dt;
    logic signed [25:0]    prod_c;
    logic [25:0]           prod_mag;
    logic [16:0]           den_mag;
    logic [7:0]            q8;
    logic [LW:0]           idx_plus2;

    assign accept  = start && !busy;
    assign grp_sel = GW'(i_group);
    assign grp_ok  = int'(i_group) < GROUPS;
    assign len_sel = r_len[grp_sel];
    assign rd_key  = t_key'(ram_rdata);

    // Writes go straight into the RAM on the accept edge
    assign ram_we    = accept && (i_op == OP_WR_KEY) && grp_ok && (int'(i_index) < POINTS);
    assign ram_waddr = AW'(int'(i_group) * POINTS + int'(i_index));
    assign ram_wdata = '{red: i_red, green: i_green, blue: i_blue, pos: i_position};

    always_comb begin
        case (r_state)
            S_LAST:  rd_ofs = r_n - 1'b1;
            S_RD_B:  rd_ofs = r_idx + 1'b1;
            default: rd_ofs = '0;
        endcase
    end
    assign ram_raddr = r_base + AW'(rd_ofs);

    always_comb begin
        case (r_chan)
            2'd0:    begin c0 = r_a.red;   c1 = r_b.red;   end
            2'd1:    begin c0 = r_a.green; c1 = r_b.green; end
            default: begin c0 = r_a.blue;  c1 = r_b.blue;  end
        endcase
    end

    assign dc       = $signed({1'b0, c0}) - $signed({1'b0, c1});
    assign dt       = $signed({1'b0, r_tt}) - $signed({1'b0, r_a.pos});
    assign prod_c   = dc * dt;
    assign prod_mag = r_prod[25] ? 26'(-r_prod) : 26'(r_prod);
    assign den_mag  = r_den[16] ? 17'(-r_den) : 17'(r_den);
    // only the low byte of the quotient survives; negation wraps the same way
    assign q8        = r_neg ? 8'(-div_quo[7:0]) : div_quo[7:0];
    assign idx_plus2 = {1'b0, r_idx} + (LW + 1)'(2);

    // ---------------- sequencer ----------------
    always_comb begin
        n_state     = r_state;
        n_valid     = 1'b0;
        n_len       = r_len;
        n_base      = r_base;
        n_n         = r_n;
        n_idx       = r_idx;
        n_time      = r_time;
        n_tt        = r_tt;
        n_a         = r_a;
        n_b         = r_b;
        n_den       = r_den;
        n_prod      = r_prod;
        n_neg       = r_neg;
        n_chan      = r_chan;
        n_rgb       = r_rgb;
        n_out_red   = r_out_red;
        n_out_green = r_out_green;
        n_out_blue  = r_out_blue;
        n_status    = r_status;
        div_start    = 1'b0;
        div_dividend = prod_mag[DIVIDEND_W-1:0];
        div_divisor  = den_mag[DIVISOR_W-1:0];

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_op)
                        OP_WR_COUNT: begin
                            if (grp_ok) begin
                                n_len[grp_sel] = (int'(i_count) > POINTS) ?
                                                 LW'(POINTS) : LW'(i_count);
                            end
                        end
                        OP_EVAL: begin
                            if (!grp_ok || len_sel < LW'(2)) begin
                                n_valid     = 1'b1;
                                n_out_red   = WHITE_RGB[23:16];
                                n_out_green = WHITE_RGB[15:8];
                                n_out_blue  = WHITE_RGB[7:0];
                                n_status    = ST_NO_SEGMENT;
                            end else begin
                                n_base  = AW'(int'(i_group) * POINTS);
                                n_n     = len_sel;
                                n_time  = i_time_req;
                                n_state = S_LAST;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_LAST: begin
                n_state = S_PERIOD;
            end
            S_PERIOD: begin
                if (rd_key.pos == '0) begin
                    n_valid     = 1'b1;
                    n_out_red   = WHITE_RGB[23:16];
                    n_out_green = WHITE_RGB[15:8];
                    n_out_blue  = WHITE_RGB[7:0];
                    n_status    = ST_ZERO_PER;
                    n_state     = S_IDLE;
                end else begin
                    div_start    = 1'b1;
                    div_dividend = DIVIDEND_W'(r_time);
                    div_divisor  = rd_key.pos;
                    n_state      = S_MOD;
                end
            end
            S_MOD: begin
                if (div_done) begin
                    n_tt    = div_rem;
                    n_state = S_RD_A;
                end
            end
            S_RD_A: begin
                n_state = S_GET_A;
            end
            S_GET_A: begin
                n_a     = rd_key;
                n_idx   = '0;
                n_state = S_RD_B;
            end
            S_RD_B: begin
                n_state = S_CHK;
            end
            S_CHK: begin
                if (r_tt <= rd_key.pos) begin
                    n_b     = rd_key;
                    n_den   = $signed({1'b0, r_a.pos}) - $signed({1'b0, rd_key.pos});
                    n_chan  = '0;
                    n_state = S_MUL;
                end else if (idx_plus2 >= {1'b0, r_n}) begin
                    n_valid     = 1'b1;
                    n_out_red   = WHITE_RGB[23:16];
                    n_out_green = WHITE_RGB[15:8];
                    n_out_blue  = WHITE_RGB[7:0];
                    n_status    = ST_NO_SEGMENT;
                    n_state     = S_IDLE;
                end else begin
                    n_a     = rd_key;
                    n_idx   = r_idx + 1'b1;
                    n_state = S_RD_B;
                end
            end
            S_MUL: begin
                if (r_den == '0) begin
                    // zero-width segment: start color
                    n_rgb[r_chan] = c0;
                    if (r_chan == 2'd2) begin
                        n_state = S_OUT;
                    end else begin
                        n_chan = r_chan + 1'b1;
                    end
                end else begin
                    n_prod  = prod_c;
                    n_state = S_DGO;
                end
            end
            S_DGO: begin
                div_start = 1'b1;
                n_neg     = r_prod[25] ^ r_den[16];
                n_state   = S_DIV;
            end
            S_DIV: begin
                if (div_done) begin
                    n_rgb[r_chan] = q8 + c0;
                    if (r_chan == 2'd2) begin
                        n_state = S_OUT;
                    end else begin
                        n_chan  = r_chan + 1'b1;
                        n_state = S_MUL;
                    end
                end
            end
            S_OUT: begin
                n_valid     = 1'b1;
                n_out_red   = r_rgb[0];
                n_out_green = r_rgb[1];
                n_out_blue  = r_rgb[2];
                n_status    = ST_OK;
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
            for (int g = 0; g < GROUPS; g++) begin
                r_len[g] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_len   <= n_len;
        end
    end

    always_ff @(posedge i_clk) begin
        r_base      <= n_base;
        r_n         <= n_n;
        r_idx       <= n_idx;
        r_time      <= n_time;
        r_tt        <= n_tt;
        r_a         <= n_a;
        r_b         <= n_b;
        r_den       <= n_den;
        r_prod      <= n_prod;
        r_neg       <= n_neg;
        r_chan      <= n_chan;
        r_rgb       <= n_rgb;
        r_out_red   <= n_out_red;
        r_out_green <= n_out_green;
        r_out_blue  <= n_out_blue;
        r_status    <= n_status;
    end

    // ---------------- submodules ----------------
    rkfi_ram #(
        .WIDTH (KW),
        .DEPTH (DEPTH)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    rkfi_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (div_dividend),
        .i_divisor   (div_divisor),
        .o_busy      (div_busy),
        .o_done      (div_done),
        .o_quotient  (div_quo),
        .o_remainder (div_rem)
    );

    assign busy        = (r_state != S_IDLE);
    assign o_valid     = r_valid;
    assign o_out_red   = r_out_red;
    assign o_out_green = r_out_green;
    assign o_out_blue  = r_out_blue;
    assign o_status    = r_status;

`ifndef SYNTHESIS
    // a result only follows an evaluate in flight or one just accepted
    a_valid_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($past(r_state) != S_IDLE) || $past(start && !busy))
        else $error("result strobe without a transaction in flight");

    // any non-ok status carries white
    a_white_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_OK) |->
        (o_out_red == 8'hFF && o_out_green == 8'hFF && o_out_blue == 8'hFF))
        else $error("error status without white color");

    // write commands complete in the accept cycle with no result
    a_write_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_op != OP_EVAL) |=> (!busy && !o_valid))
        else $error("write transaction raised busy or a result");

    // the shared divider is never restarted mid-operation
    a_div_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_busy)
        else $error("divider started while busy");

    // while waiting on the divider it is actually working or just finished
    a_div_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV || r_state == S_MOD) |-> (div_busy || div_done))
        else $error("sequencer waits on an idle divider");
`endif

endmodule

[hw/rtl/rkfi_ram.sv]
// ----------------------------------------------------------------------------
// rkfi_ram: generic simple dual-port RAM
// One write port, one read port with registered read data. No reset.
// ----------------------------------------------------------------------------
module rkfi_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 192
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/rkfi_div.sv]
// ----------------------------------------------------------------------------
// rkfi_div: shared iterative unsigned divider
// Restoring division, one quotient bit per cycle; gives quotient and remainder.
// ----------------------------------------------------------------------------
module rkfi_div
    import rkfi_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [DIVIDEND_W-1:0] i_dividend,
    input  logic [DIVISOR_W-1:0]  i_divisor,
    output logic                  o_busy,
    output logic                  o_done,
    output logic [DIVIDEND_W-1:0] o_quotient,
    output logic [DIVISOR_W-1:0]  o_remainder
);

    localparam int CW = $clog2(DIVIDEND_W);

    logic                  r_busy, n_busy;
    logic                  r_done, n_done;
    logic [CW-1:0]         r_cnt, n_cnt;
    logic [DIVIDEND_W-1:0] r_quo, n_quo;
    logic [DIVISOR_W-1:0]  r_rem, n_rem;
    logic [DIVISOR_W-1:0]  r_dvs, n_dvs;

    logic [DIVISOR_W:0]    shifted;
    logic [DIVISOR_W:0]    diff;
    logic                  ge;

    assign shifted = {r_rem, r_quo[DIVIDEND_W-1]};
    assign ge      = shifted >= {1'b0, r_dvs};
    assign diff    = shifted - {1'b0, r_dvs};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_dvs  = r_dvs;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CW'(DIVIDEND_W - 1);
            n_quo  = i_dividend;
            n_rem  = '0;
            n_dvs  = i_divisor;
        end else if (r_busy) begin
            // remainder always stays below the divisor, so 16 bits suffice
            n_rem = ge ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
            n_quo = {r_quo[DIVIDEND_W-2:0], ge};
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_cnt = r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt <= n_cnt;
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_dvs <= n_dvs;
    end

    assign o_busy      = r_busy;
    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

[tb/tb_rgb_keyframe_interpolator.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rgb_keyframe_interpolator: self-checking bench for the keyframe color block
// Loads color curves, evaluates them at chosen times and compares every color
// result against an in-bench model of the curves. A short directed pass is
// followed by random curve loads, evaluations and stray commands.
// ----------------------------------------------------------------------------
module tb_rgb_keyframe_interpolator
    import rkfi_pkg::*;
();

    localparam int N_GROUPS     = 12;
    localparam int N_POINTS     = 16;
    localparam int RANDOM_ITEMS = 550;
    // i_op value with no function; the block takes it and does nothing
    localparam logic [1:0] OP_NOP = 2'd3;
    // leave margin at the end for the slowest evaluate to finish
    localparam int TAIL_CYCLES  = 200;

    // One command transaction as presented on the input ports
    typedef struct {
        logic [1:0]  op;
        logic [3:0]  grp;
        logic [3:0]  idx;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [15:0] pos;
        logic [4:0]  cnt;
        logic [15:0] tm;
    } t_cmd;

    // One color result as seen on the output ports
    typedef struct {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [1:0] status;
    } t_color;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  i_op;
    logic [3:0]  i_group;
    logic [3:0]  i_index;
    logic [7:0]  i_red;
    logic [7:0]  i_green;
    logic [7:0]  i_blue;
    logic [15:0] i_position;
    logic [4:0]  i_count;
    logic [15:0] i_time_req;
    logic        o_valid;
    logic [7:0]  o_out_red;
    logic [7:0]  o_out_green;
    logic [7:0]  o_out_blue;
    logic [1:0]  o_status;

    // Bench copy of the curve memory. key_written tracks which slots hold
    // real data: the block's keyframe RAM is garbage until written, so an
    // evaluate is only issued when every slot it may read has been loaded.
    t_key       curve_keys  [N_GROUPS][N_POINTS];
    logic [4:0] curve_len   [N_GROUPS];
    bit         key_written [N_GROUPS][N_POINTS];

    t_color     pending_colors[$];   // colors still owed by the block, oldest first
    int         mismatches = 0;
    int         work_items = 0;      // accepted commands that do something

    rgb_keyframe_interpolator #(
        .GROUPS (N_GROUPS),
        .POINTS (N_POINTS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_op        (i_op),
        .i_group     (i_group),
        .i_index     (i_index),
        .i_red       (i_red),
        .i_green     (i_green),
        .i_blue      (i_blue),
        .i_position  (i_position),
        .i_count     (i_count),
        .i_time_req  (i_time_req),
        .o_valid     (o_valid),
        .o_out_red   (o_out_red),
        .o_out_green (o_out_green),
        .o_out_blue  (o_out_blue),
        .o_status    (o_status)
    );

    // 100 MHz clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Color prediction
    // ------------------------------------------------------------------

    // One channel of the segment blend: (c0 - c1) * (t - p0) / (p0 - p1) + c0,
    // signed, quotient truncated toward zero, low byte kept.
    function automatic logic [7:0] blend_channel(input logic [7:0] c0, input logic [7:0] c1,
                                                 input logic [15:0] t, input logic [15:0] p0,
                                                 input logic [15:0] p1);
        int span;
        int v;
        span = int'(p0) - int'(p1);
        if (span == 0) begin
            return c0;   // zero-width segment holds its start color
        end
        v = ((int'(c0) - int'(c1)) * (int'(t) - int'(p0))) / span + int'(c0);
        return v[7:0];
    endfunction

    function automatic t_color curve_color(input logic [3:0] g, input logic [15:0] t);
        t_color      res;
        int          n;
        int          k;
        logic [15:0] period;
        logic [15:0] tt;
        t_key        ka;
        t_key        kb;
        res.red    = WHITE_RGB[23:16];
        res.green  = WHITE_RGB[15:8];
        res.blue   = WHITE_RGB[7:0];
        res.status = ST_NO_SEGMENT;
        if (g >= N_GROUPS) begin
            return res;
        end
        n = curve_len[g];
        if (n < 2) begin
            return res;
        end
        period = curve_keys[g][n-1].pos;
        if (period == 0) begin
            res.status = ST_ZERO_PER;
            return res;
        end
        tt = t % period;
        // first segment whose end position reaches the reduced time
        for (k = 0; k + 1 < n; k++) begin
            ka = curve_keys[g][k];
            kb = curve_keys[g][k+1];
            if (tt <= kb.pos) begin
                res.red    = blend_channel(ka.red,   kb.red,   tt, ka.pos, kb.pos);
                res.green  = blend_channel(ka.green, kb.green, tt, ka.pos, kb.pos);
                res.blue   = blend_channel(ka.blue,  kb.blue,  tt, ka.pos, kb.pos);
                res.status = ST_OK;
                return res;
            end
        end
        return res;
    endfunction

    // Update the curve copy for an accepted command; queue the color it owes.
    task automatic apply_command(input t_cmd c);
        case (c.op)
            OP_WR_KEY: begin
                if (c.grp < N_GROUPS) begin
                    curve_keys[c.grp][c.idx] = '{red: c.red, green: c.green,
                                                 blue: c.blue, pos: c.pos};
                    key_written[c.grp][c.idx] = 1'b1;
                    work_items++;
                end
            end
            OP_WR_COUNT: begin
                if (c.grp < N_GROUPS) begin
                    curve_len[c.grp] = (c.cnt > N_POINTS) ? 5'(N_POINTS) : c.cnt;
                    work_items++;
                end
            end
            OP_EVAL: begin
                pending_colors.push_back(curve_color(c.grp, c.tm));
                work_items++;
            end
            default: ;
        endcase
    endtask

    // True when an evaluate of group g reads only loaded keyframe slots
    function automatic bit curve_readable(input logic [3:0] g);
        int k;
        if (g >= N_GROUPS || curve_len[g] < 2) begin
            return 1'b1;
        end
        for (k = 0; k < curve_len[g]; k++) begin
            if (!key_written[g][k]) begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Command driver
    // ------------------------------------------------------------------

    // Present one command after a random idle gap with start low and hold it until the
    // edge that takes it (start high, busy low). Returns on that edge with
    // start still high, so a back-to-back command needs no extra toggle.
    task automatic send_cmd(input t_cmd c);
        int gap;
        gap = $urandom_range(0, 3);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start      <= 1'b1;
        i_op       <= c.op;
        i_group    <= c.grp;
        i_index    <= c.idx;
        i_red      <= c.red;
        i_green    <= c.green;
        i_blue     <= c.blue;
        i_position <= c.pos;
        i_count    <= c.cnt;
        i_time_req <= c.tm;
        do begin
            @(posedge i_clk);
        end while (busy);
        apply_command(c);
    endtask

    // Unused fields carry random values so they toggle regardless of op
    function automatic t_cmd scrambled_cmd(input logic [1:0] op, input logic [3:0] g);
        t_cmd c;
        c.op    = op;
        c.grp   = g;
        c.idx   = 4'($urandom);
        c.red   = 8'($urandom);
        c.green = 8'($urandom);
        c.blue  = 8'($urandom);
        c.pos   = 16'($urandom);
        c.cnt   = 5'($urandom);
        c.tm    = 16'($urandom);
        return c;
    endfunction

    task automatic write_key(input logic [3:0] g, input logic [3:0] slot, input logic [7:0] r,
                             input logic [7:0] gr, input logic [7:0] b, input logic [15:0] p);
        t_cmd c;
        c       = scrambled_cmd(OP_WR_KEY, g);
        c.idx   = slot;
        c.red   = r;
        c.green = gr;
        c.blue  = b;
        c.pos   = p;
        send_cmd(c);
    endtask

    task automatic write_count(input logic [3:0] g, input logic [4:0] n);
        t_cmd c;
        c     = scrambled_cmd(OP_WR_COUNT, g);
        c.cnt = n;
        send_cmd(c);
    endtask

    task automatic eval_at(input logic [3:0] g, input logic [15:0] t);
        t_cmd c;
        c    = scrambled_cmd(OP_EVAL, g);
        c.tm = t;
        send_cmd(c);
    endtask

    // Drop start and hold off until every owed color has come back
    task automatic drain_results();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_colors.size() != 0) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Result checker: a result lives for one cycle and is taken at the edge
    // that ends it, so o_valid is sampled on every rising edge.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_color want;
        if (i_rst_n && o_valid) begin
            if (pending_colors.size() == 0) begin
                $error("color result with no evaluate outstanding");
                mismatches++;
            end else begin
                want = pending_colors.pop_front();
                if (o_out_red !== want.red) begin
                    $error("out_red: expected %0d, got %0d", want.red, o_out_red);
                    mismatches++;
                end
                if (o_out_green !== want.green) begin
                    $error("out_green: expected %0d, got %0d", want.green, o_out_green);
                    mismatches++;
                end
                if (o_out_blue !== want.blue) begin
                    $error("out_blue: expected %0d, got %0d", want.blue, o_out_blue);
                    mismatches++;
                end
                if (o_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_status);
                    mismatches++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Counts come up zero, so any group evaluates to white / no segment
    task automatic test_after_reset();
        eval_at(4'd0, 16'd0);
        eval_at(4'd11, 16'hFFFF);
        eval_at(4'd15, 16'h1234);
        drain_results();
    endtask

    // Extreme colors and positions, a zero-width first segment, time wrap
    task automatic test_interpolation();
        write_key(4'd11, 4'd0, 8'd255, 8'd0,   8'd128, 16'd0);
        write_key(4'd11, 4'd1, 8'd0,   8'd255, 8'd1,   16'd0);
        write_key(4'd11, 4'd2, 8'd255, 8'd255, 8'd0,   16'd1000);
        write_key(4'd11, 4'd3, 8'd0,   8'd0,   8'd255, 16'hFFFF);
        write_count(4'd11, 5'd4);
        eval_at(4'd11, 16'd0);       // lands on the zero-width segment
        eval_at(4'd11, 16'd500);
        eval_at(4'd11, 16'd1000);
        eval_at(4'd11, 16'hFFFE);
        eval_at(4'd11, 16'hFFFF);    // wraps to zero
        drain_results();
    endtask

    // Last keyframe at position zero: white with zero-period status
    task automatic test_zero_period();
        write_key(4'd0, 4'd0,  8'd10, 8'd20, 8'd30, 16'hFFFF);
        write_key(4'd0, 4'd1,  8'd40, 8'd50, 8'd60, 16'd0);
        write_key(4'd0, 4'd15, 8'd1,  8'd2,  8'd3,  16'd7);
        write_count(4'd0, 5'd2);
        eval_at(4'd0, 16'd777);
        drain_results();
    endtask

    // Fewer than two points in use
    task automatic test_short_curve();
        write_count(4'd11, 5'd1);
        eval_at(4'd11, 16'd500);
        write_count(4'd11, 5'd0);
        eval_at(4'd11, 16'd500);
        drain_results();
    endtask

    // Writes to groups past the last one and the spare op code change nothing
    task automatic test_ignored_commands();
        write_key(4'd13, 4'd15, 8'd1, 8'd2, 8'd3, 16'd100);
        write_count(4'd15, 5'd2);
        send_cmd(scrambled_cmd(OP_NOP, 4'd3));
        eval_at(4'd13, 16'd100);
        drain_results();
    endtask

    // Load a whole curve, set its count, then evaluate it a few times
    task automatic load_random_curve();
        logic [3:0]  g;
        logic [15:0] p;
        int          n;
        int          style;
        int          cur;
        int          k;
        int          hi;
        g     = 4'($urandom_range(0, N_GROUPS - 1));
        n     = ($urandom_range(0, 6) == 0) ? $urandom_range(6, N_POINTS) : $urandom_range(2, 5);
        style = $urandom_range(0, 9);
        cur   = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 500);
        for (k = 0; k < n; k++) begin
            if (style == 8) begin
                p = 16'($urandom);           // arbitrary order
            end else begin
                // mostly rising, some repeated positions (zero-width segments)
                if (k > 0 && $urandom_range(0, 4) != 0) begin
                    cur += $urandom_range(1, 4000);
                end
                p = 16'(cur);
            end
            if (k == n - 1 && style == 9) begin
                p = 16'd0;
            end
            if (k == n - 1 && style == 7) begin
                p = 16'hFFFF;
            end
            write_key(g, 4'(k), 8'($urandom), 8'($urandom), 8'($urandom), p);
        end
        // a full curve also takes oversized counts, which saturate
        write_count(g, 5'((n == N_POINTS) ? $urandom_range(N_POINTS, 31) : n));
        hi = 2 * int'(curve_keys[g][n-1].pos);
        if (hi > 65535) begin
            hi = 65535;
        end
        repeat ($urandom_range(2, 6)) begin
            eval_at(g, 16'(($urandom_range(0, 2) == 0) ? $urandom_range(0, 65535)
                                                        : $urandom_range(0, hi)));
        end
    endtask

    // A stray command of any kind; evaluates are steered off unloaded slots
    task automatic send_noise();
        t_cmd c;
        c = scrambled_cmd(2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)));
        if (c.op == OP_EVAL && !curve_readable(c.grp)) begin
            c.grp = 4'($urandom_range(N_GROUPS, 15));
        end
        send_cmd(c);
    endtask

    task automatic test_random_traffic();
        int first;
        first = work_items;
        while (work_items - first < RANDOM_ITEMS) begin
            if ($urandom_range(0, 3) != 0) begin
                load_random_curve();
            end else begin
                repeat ($urandom_range(1, 4)) send_noise();
            end
            if ($urandom_range(0, 9) == 0) begin
                drain_results();
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        foreach (curve_len[g]) curve_len[g] = '0;
        foreach (key_written[g, k]) key_written[g][k] = 1'b0;
        i_rst_n    <= 1'b0;
        start      <= 1'b0;
        i_op       <= OP_WR_KEY;
        i_group    <= '0;
        i_index    <= '0;
        i_red      <= '0;
        i_green    <= '0;
        i_blue     <= '0;
        i_position <= '0;
        i_count    <= '0;
        i_time_req <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_after_reset();
        test_interpolation();
        test_zero_period();
        test_short_curve();
        test_ignored_commands();
        test_random_traffic();

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pending_colors.size() != 0) begin
            $error("%0d color results never arrived", pending_colors.size());
            mismatches++;
        end
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // Hang guard: ends a run that never reaches $finish as failed
    initial begin
        #(20_000_000);
        $display("simulation failed");
        $finish;
    end

endmodule

[sim.f]
hw/rtl/rkfi_pkg.sv
hw/rtl/rkfi_ram.sv
hw/rtl/rkfi_div.sv
hw/rtl/rgb_keyframe_interpolator.sv
tb/tb_rgb_keyframe_interpolator.sv
